/* rtl/hcid_pkg.sv */
// Shared types and constants for the HCI H4 packet deframer.
package hcid_pkg;

   // Packet kind codes as they appear on the result stream
   localparam logic [2:0] KIND_CMD = 3'd0;
   localparam logic [2:0] KIND_ACL = 3'd1;
   localparam logic [2:0] KIND_SCO = 3'd2;
   localparam logic [2:0] KIND_ISO = 3'd3;
   localparam logic [2:0] KIND_EVT = 3'd4;
   localparam logic [2:0] KIND_THR = 3'd5;

   // H4 type bytes
   localparam logic [7:0] TYPE_CMD = 8'h01;
   localparam logic [7:0] TYPE_ACL = 8'h02;
   localparam logic [7:0] TYPE_SCO = 8'h03;
   localparam logic [7:0] TYPE_EVT = 8'h04;
   localparam logic [7:0] TYPE_ISO = 8'h05;

   // ISO length keeps 14 bits: high byte masked
   localparam logic [7:0] ISO_HIGH_MASK = 8'h3F;

   // Preamble sizes
   localparam logic [1:0] PRE_LEN_EVT   = 2'd2;
   localparam logic [1:0] PRE_LEN_SHORT = 2'd3;

   typedef enum logic [1:0] {
      PH_TYPE = 2'd0,
      PH_PRE  = 2'd1,
      PH_PAY  = 2'd2
   } phase_type;

   // One result word
   typedef struct packed {
      logic       dropped;
      logic       is_first;
      logic       is_last;
      logic [2:0] packet_kind;
      logic [7:0] out_byte;
   } result_type;

endpackage

/* rtl/hci_h4_packet_deframer.sv */
// Top level: H4 byte stream in, bytes marked with kind and packet boundaries out.
// Results are registered in the output stage before they show on rsp_*.
// Throughput: one word per cycle while rsp_tready is high; the skid stage behind the result
// register keeps req_tready high while a single result waits.
// Reset: synchronous, active high; clears phase, counters, thread code and valids.
module hci_h4_packet_deframer (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data,    // thread_type_code
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,      // [7:0] rx_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,      // [7:0] out_byte
   output logic [4:0] rsp_tuser,      // [2:0] packet_kind, [3] is_first, [4] dropped
   output logic       rsp_tlast       // is_last
);
   import hcid_pkg::*;

   result_type parse_result;
   result_type out_result;
   logic       byte_accept;

   assign byte_accept = req_tvalid && req_tready;

   hcid_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .byte_accept (byte_accept),
      .rx_byte     (req_tdata),
      .result      (parse_result)
   );

   hcid_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (parse_result),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_result)
   );

   // Result word onto the stream fields
   assign rsp_tdata = out_result.out_byte;
   assign rsp_tuser = {out_result.dropped, out_result.is_first, out_result.packet_kind};
   assign rsp_tlast = out_result.is_last;

endmodule

/* rtl/hcid_parser.sv */
// Packet boundary tracker: type, preamble and payload phases, one byte per cycle while bytes are accepted.
module hcid_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [7:0]          csr_wr_data,
   input  logic                byte_accept,
   input  logic [7:0]          rx_byte,
   output hcid_pkg::result_type result
);
   import hcid_pkg::*;

   logic [7:0]  thread_code_ff;
   phase_type   phase_ff, phase_in;
   logic [2:0]  kind_ff, kind_in;
   logic [15:0] count_ff, count_in;
   logic [15:0] pay_len_ff, pay_len_in;
   logic [7:0]  len_low_ff, len_low_in;

   logic        type_known;
   logic [2:0]  type_kind;
   logic        two_byte_len;
   logic [2:0]  pre_size;
   logic [2:0]  pre_idx;
   logic [16:0] pay_idx;
   logic [7:0]  len_high;
   logic [15:0] new_len;

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         thread_code_ff <= '0;
      end else if (csr_wr_en) begin
         thread_code_ff <= csr_wr_data;
      end
   end

   // Type byte decode; standard codes win over the thread code
   always_comb begin
      type_known = 1'b1;
      type_kind  = KIND_CMD;
      priority if (rx_byte == TYPE_CMD) begin
         type_kind = KIND_CMD;
      end else if (rx_byte == TYPE_ACL) begin
         type_kind = KIND_ACL;
      end else if (rx_byte == TYPE_SCO) begin
         type_kind = KIND_SCO;
      end else if (rx_byte == TYPE_EVT) begin
         type_kind = KIND_EVT;
      end else if (rx_byte == TYPE_ISO) begin
         type_kind = KIND_ISO;
      end else if (thread_code_ff != 8'd0 && rx_byte == thread_code_ff) begin
         type_kind = KIND_THR;
      end else begin
         type_known = 1'b0;
      end
   end

   // Preamble geometry of the current packet
   always_comb begin
      two_byte_len = (kind_ff == KIND_ACL) || (kind_ff == KIND_ISO) || (kind_ff == KIND_THR);
      if (two_byte_len) begin
         pre_size = 3'd4;
      end else if (kind_ff == KIND_EVT) begin
         pre_size = {1'b0, PRE_LEN_EVT};
      end else begin
         pre_size = {1'b0, PRE_LEN_SHORT};
      end
      pre_idx  = count_ff[2:0] + 3'd1;
      pay_idx  = {1'b0, count_ff} + 17'd1;
      len_high = (kind_ff == KIND_ISO) ? (rx_byte & ISO_HIGH_MASK) : rx_byte;
      new_len  = two_byte_len ? {len_high, len_low_ff} : {8'd0, rx_byte};
   end

   // Next state and result for the byte at the input
   always_comb begin
      phase_in   = phase_ff;
      kind_in    = kind_ff;
      count_in   = count_ff;
      pay_len_in = pay_len_ff;
      len_low_in = len_low_ff;

      result.out_byte    = rx_byte;
      result.packet_kind = kind_ff;
      result.is_first    = 1'b0;
      result.is_last     = 1'b0;
      result.dropped     = 1'b0;

      unique case (phase_ff)
         PH_PRE: begin
            if (pre_idx >= pre_size) begin
               count_in   = '0;
               pay_len_in = new_len;
               if (new_len == 16'd0) begin
                  result.is_last = 1'b1;
                  phase_in       = PH_TYPE;
               end else begin
                  phase_in = PH_PAY;
               end
            end else begin
               if (pre_idx == pre_size - 3'd1) begin
                  len_low_in = rx_byte;
               end
               count_in = {13'd0, pre_idx};
            end
         end
         PH_PAY: begin
            if (pay_idx >= {1'b0, pay_len_ff}) begin
               result.is_last = 1'b1;
               phase_in       = PH_TYPE;
               count_in       = '0;
               pay_len_in     = '0;
            end else begin
               count_in = pay_idx[15:0];
            end
         end
         default: begin
            // type phase (unused code behaves the same)
            if (!type_known) begin
               result.dropped     = 1'b1;
               result.packet_kind = KIND_CMD;
               phase_in           = PH_TYPE;
            end else begin
               result.is_first    = 1'b1;
               result.packet_kind = type_kind;
               kind_in            = type_kind;
               phase_in           = PH_PRE;
               count_in           = '0;
               pay_len_in         = '0;
               len_low_in         = '0;
            end
         end
      endcase
   end

   // State registers advance on each accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_TYPE;
         kind_ff    <= KIND_CMD;
         count_ff   <= '0;
         pay_len_ff <= '0;
         len_low_ff <= '0;
      end else if (byte_accept) begin
         phase_ff   <= phase_in;
         kind_ff    <= kind_in;
         count_ff   <= count_in;
         pay_len_ff <= pay_len_in;
         len_low_ff <= len_low_in;
      end
   end

endmodule

/* rtl/hcid_out_stage.sv */
// Result register with a skid stage so input is taken while a result waits.
module hcid_out_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  hcid_pkg::result_type in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output hcid_pkg::result_type out_data
);
   import hcid_pkg::*;

   logic       out_valid_ff, out_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type out_data_ff, out_data_in;
   result_type skid_data_ff, skid_data_in;
   logic       accept;
   logic       take;

   assign in_ready  = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;
   assign accept    = in_valid && in_ready;
   assign take      = out_valid_ff && out_ready;

   // Refill the result register from the skid stage first, then the input
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || take) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = accept;
            out_data_in  = in_data;
         end
      end else if (accept) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule
